// ===== rtl/tcq_pkg.sv =====
// Shared types and constants for the tile-coded Q update engine.
// No dependencies.
`timescale 1ns / 1ps
package tcq_pkg;
  localparam int NUM_TILES_DEF   = 4;
  localparam int TILE_ROWS_DEF   = 255;
  localparam int NUM_ACTIONS_DEF = 128;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 7;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam logic [16:0] LR_RESET   = 17'd6554;
  localparam logic [16:0] DISC_RESET = 17'd58982;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_STEP  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // One classified command from the front part to the back part.
  typedef struct packed {
    func_t              func;
    logic               table_sel;
    logic [ROW_W-1:0]   abs_row;
    logic [ROW_W-1:0]   srow;
    logic [COL_W-1:0]   col;
    logic signed [31:0] value;
    logic               last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WAIT, ST_MAXA, ST_MAXB, ST_G, ST_URD, ST_UWAIT, ST_UMUL,
    ST_URND, ST_UWR
  } state_t;
endpackage

// ===== rtl/tcq_front.sv =====
// Front part: accepts items, forms table columns and search rows.
// Depends on tcq_pkg.
`timescale 1ns / 1ps
module tcq_front #(
  parameter int TILE_ROWS   = tcq_pkg::TILE_ROWS_DEF,
  parameter int NUM_ACTIONS = tcq_pkg::NUM_ACTIONS_DEF
) (
  input  logic                 start,
  input  logic                 q_full,
  input  logic [1:0]           in_func,
  input  logic                 in_table_sel,
  input  logic [9:0]           in_abs_row,
  input  logic [7:0]           in_action,
  input  logic signed [31:0]   in_entry_value,
  input  logic [1:0]           in_tile,
  input  logic [7:0]           in_visit_row,
  input  logic signed [31:0]   in_reward,
  input  logic                 in_last,
  output logic                 push,
  output tcq_pkg::cmd_t        cmd
);
  import tcq_pkg::*;
  localparam logic [ROW_W-1:0] STRIDE = ROW_W'((TILE_ROWS + 1) % 1024);
  localparam logic [7:0] NA = 8'(NUM_ACTIONS);

  logic [7:0] col8;
  logic [ROW_W-1:0] toff;

  always_comb begin
    if (in_action == 8'd0) col8 = 8'd0;
    else if (in_action > NA) col8 = NA - 8'd1;
    else col8 = in_action - 8'd1;
    toff = ROW_W'(in_tile) * STRIDE;
  end

  assign push = start && !q_full;
  always_comb begin
    cmd.func      = func_t'(in_func);
    cmd.table_sel = in_table_sel;
    cmd.abs_row   = in_abs_row;
    cmd.srow      = ROW_W'({2'd0, in_visit_row}) + toff;
    cmd.col       = col8[COL_W-1:0];
    cmd.value     = (in_func == FN_WRITE) ? in_entry_value : in_reward;
    cmd.last      = in_last;
  end
endmodule

// ===== rtl/tcq_queue.sv =====
// Two-entry command queue between front and back parts.
// Depends on tcq_pkg.
`timescale 1ns / 1ps
module tcq_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcq_pkg::cmd_t din,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output tcq_pkg::cmd_t dout
);
  import tcq_pkg::*;
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/tcq_back.sv =====
// Back part: table memories, max search and update sequencer.
// Depends on tcq_pkg.
`timescale 1ns / 1ps
module tcq_back #(
  parameter int NUM_TILES = tcq_pkg::NUM_TILES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  tcq_pkg::cmd_t      cmd,
  output logic               pop,
  input  logic [16:0]        learn_rate,
  input  logic [16:0]        discount,
  output logic               out_valid,
  output logic               out_kind,
  output logic [9:0]         out_row,
  output logic signed [31:0] out_value,
  output logic               out_end_of_run
);
  import tcq_pkg::*;
  localparam int PW = $clog2(NUM_TILES + 1);
  localparam int IW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;

  logic signed [31:0] qmem [2**ADDR_W];
  logic signed [31:0] hmem [2**ADDR_W];
  logic signed [31:0] qrd_r, hrd_r;

  state_t st_r, st_nxt;
  cmd_t   c_r;
  logic [ROW_W-1:0] prow_r [NUM_TILES];
  logic [PW-1:0] pcnt_r;
  logic [IW-1:0] idx_r;
  logic signed [31:0] best_r;
  logic signed [33:0] g_r;
  logic signed [35:0] d_r;
  logic signed [53:0] p_r;
  logic signed [31:0] e_r;

  logic rd_en, wr_en, wr_h;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic [ROW_W-1:0] cur_row;
  logic signed [37:0] a_w;
  logic signed [38:0] nv;
  logic signed [31:0] sat_v;
  logic signed [49:0] gp;

  assign cur_row = prow_r[idx_r];
  assign gp = $signed({1'b0, discount}) * best_r;
  // The rounded step can reach about 2^34, so it keeps every bit before saturation.
  assign a_w = 38'((p_r + 54'sd32768) >>> 16);
  assign nv  = 39'(e_r) + 39'(a_w);
  assign sat_v = (nv > 39'sd2147483647) ? 32'sh7fffffff :
                 (nv < -39'sd2147483648) ? 32'sh80000000 : nv[31:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      qrd_r <= qmem[rd_addr];
      hrd_r <= hmem[rd_addr];
    end
    if (wr_en && !wr_h) qmem[wr_addr] <= wr_data;
    if (wr_en && wr_h)  hmem[wr_addr] <= wr_data;
  end

  always_comb begin
    st_nxt = st_r; pop = 1'b0;
    rd_en = 1'b0; rd_addr = {cmd.abs_row, cmd.col};
    wr_en = 1'b0; wr_h = c_r.table_sel; wr_addr = {cur_row, c_r.col};
    wr_data = sat_v;
    unique case (st_r)
      ST_IDLE: if (!empty) begin
        pop = 1'b1;
        unique case (cmd.func)
          FN_WRITE: begin
            wr_en = 1'b1; wr_h = cmd.table_sel;
            wr_addr = {cmd.abs_row, cmd.col}; wr_data = cmd.value;
          end
          FN_READ: begin rd_en = 1'b1; st_nxt = ST_WAIT; end
          FN_STEP: begin
            rd_en = 1'b1; rd_addr = {cmd.srow, cmd.col}; st_nxt = ST_MAXA;
          end
          default: ;
        endcase
      end
      ST_WAIT: st_nxt = ST_IDLE;
      ST_MAXA: st_nxt = ST_MAXB;
      ST_MAXB: st_nxt = c_r.last ? ST_G : ST_IDLE;
      ST_G: st_nxt = (pcnt_r == '0) ? ST_IDLE : ST_URD;
      ST_URD: begin
        rd_en = 1'b1; rd_addr = {cur_row, c_r.col}; st_nxt = ST_UWAIT;
      end
      ST_UWAIT: st_nxt = ST_UMUL;
      ST_UMUL: st_nxt = ST_URND;
      ST_URND: st_nxt = ST_UWR;
      ST_UWR: begin
        wr_en = 1'b1;
        st_nxt = (PW'(idx_r) + PW'(1) == pcnt_r) ? ST_IDLE : ST_URD;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) c_r <= cmd;
    if (st_r == ST_WAIT) begin
      out_kind <= 1'b0; out_row <= c_r.abs_row;
      out_value <= c_r.table_sel ? hrd_r : qrd_r; out_end_of_run <= 1'b0;
    end
    if (st_r == ST_G) g_r <= 34'((64'(gp) + 64'sd32768) >>> 16);
    if (st_r == ST_UWAIT) begin
      e_r <= c_r.table_sel ? hrd_r : qrd_r;
      d_r <= 36'(c_r.value) + 36'(g_r) - 36'(c_r.table_sel ? hrd_r : qrd_r);
    end
    if (st_r == ST_UMUL) p_r <= $signed({1'b0, learn_rate}) * d_r;
    if (st_r == ST_UWR) begin
      out_kind <= 1'b1; out_row <= cur_row;
      out_value <= sat_v;
      out_end_of_run <= (PW'(idx_r) + PW'(1) == pcnt_r);
    end
    if (st_r == ST_MAXA && pcnt_r < PW'(NUM_TILES)) prow_r[pcnt_r[IW-1:0]] <= c_r.abs_row;
    if (!rst_n) begin
      st_r <= ST_IDLE; pcnt_r <= '0; idx_r <= '0;
      best_r <= 32'sh80000000; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= (st_r == ST_WAIT) || (st_r == ST_UWR);
      if (st_r == ST_MAXA) begin
        if (hrd_r > best_r) best_r <= (qrd_r > hrd_r) ? qrd_r : hrd_r;
        else if (qrd_r > best_r) best_r <= qrd_r;
        if (pcnt_r < PW'(NUM_TILES)) pcnt_r <= pcnt_r + PW'(1);
      end
      if (st_r == ST_G) begin
        idx_r <= '0; best_r <= 32'sh80000000;
      end
      if (st_r == ST_UWR) begin
        if (PW'(idx_r) + PW'(1) == pcnt_r) pcnt_r <= '0;
        else idx_r <= idx_r + IW'(1);
      end
    end
  end
endmodule

// ===== rtl/tile_coded_q_update.sv =====
// Top level of the tile-coded Q update engine.
// Depends on tcq_pkg, tcq_front, tcq_queue and tcq_back.
`timescale 1ns / 1ps
// Items enter on start when busy is low and pass through a two-entry queue
// to a sequencer that owns the Q and H memories. Once an item leaves the
// queue, the sequencer carries out a write, a read or a tile step; the item
// marked last then forms the discounted maximum and takes each recorded
// update row through read, wait, multiply, round and write back, with one
// memory access per cycle. Every result is shown for one cycle with
// out_valid high and must be taken then: the receiver cannot stall the
// block. The tables are not cleared at reset.
module tile_coded_q_update #(
  parameter int NUM_TILES   = tcq_pkg::NUM_TILES_DEF,
  parameter int TILE_ROWS   = tcq_pkg::TILE_ROWS_DEF,
  parameter int NUM_ACTIONS = tcq_pkg::NUM_ACTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic               in_table_sel,
  input  logic [9:0]         in_abs_row,
  input  logic [7:0]         in_action,
  input  logic signed [31:0] in_entry_value,
  input  logic [1:0]         in_tile,
  input  logic [7:0]         in_visit_row,
  input  logic signed [31:0] in_reward,
  input  logic               in_last,
  output logic               out_valid,
  output logic               out_kind,
  output logic [9:0]         out_row,
  output logic signed [31:0] out_value,
  output logic               out_end_of_run,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:2]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tcq_pkg::*;

  // Configuration registers: learn rate at byte 0, discount at byte 4.
  logic [16:0] cfg_learn_rate_r, cfg_discount_r;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {15'd0, cfg_discount_r} : {15'd0, cfg_learn_rate_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_learn_rate_r <= LR_RESET;
      cfg_discount_r   <= DISC_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) cfg_discount_r <= pwdata[16:0];
      else cfg_learn_rate_r <= pwdata[16:0];
    end
  end

  logic push, q_full, q_empty, pop;
  cmd_t fcmd, qcmd;

  // The queue holds two items, so busy is simply the queue being full.
  assign busy = q_full;

  tcq_front #(.TILE_ROWS(TILE_ROWS), .NUM_ACTIONS(NUM_ACTIONS)) u_front (
    .start, .q_full,
    .in_func, .in_table_sel, .in_abs_row, .in_action, .in_entry_value,
    .in_tile, .in_visit_row, .in_reward, .in_last,
    .push, .cmd(fcmd)
  );

  tcq_queue u_queue (
    .clk, .rst_n, .push, .din(fcmd), .pop, .full(q_full), .empty(q_empty),
    .dout(qcmd)
  );

  tcq_back #(.NUM_TILES(NUM_TILES)) u_back (
    .clk, .rst_n, .empty(q_empty), .cmd(qcmd), .pop,
    .learn_rate(cfg_learn_rate_r), .discount(cfg_discount_r),
    .out_valid, .out_kind, .out_row, .out_value, .out_end_of_run
  );
endmodule

// ===== tb/tile_coded_q_update_tb.sv =====
// Self-checking testbench for the tile-coded Q update engine (tile_coded_q_update).
// It depends on tcq_pkg and the RTL. A queue-fed driver and a clocked monitor compare
// each result with a built-in prediction of the Q and H tables and the learning update.
`timescale 1ns / 1ps
module tile_coded_q_update_tb;
  import tcq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_COLS = 128;

  // One input item as the driver presents it on the in_ ports.
  typedef struct {
    func_t              func;
    bit                 tsel;
    bit [9:0]           row;
    bit [7:0]           act;
    bit signed [31:0]   val;
    bit [1:0]           tile;
    bit [7:0]           vis;
    bit signed [31:0]   rew;
    bit                 last;
  } cmd_item_t;

  // One result item as it appears on the out_ ports.
  typedef struct {
    bit                 kind;
    bit [9:0]           row;
    bit signed [31:0]   value;
    bit                 eor;
  } entry_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic               in_table_sel;
  logic [9:0]         in_abs_row;
  logic [7:0]         in_action;
  logic signed [31:0] in_entry_value;
  logic [1:0]         in_tile;
  logic [7:0]         in_visit_row;
  logic signed [31:0] in_reward;
  logic               in_last;
  logic               out_valid;
  logic               out_kind;
  logic [9:0]         out_row;
  logic signed [31:0] out_value;
  logic               out_end_of_run;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:2]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  tile_coded_q_update i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_table_sel(in_table_sel), .in_abs_row(in_abs_row),
    .in_action(in_action), .in_entry_value(in_entry_value), .in_tile(in_tile),
    .in_visit_row(in_visit_row), .in_reward(in_reward), .in_last(in_last),
    .out_valid(out_valid), .out_kind(out_kind), .out_row(out_row),
    .out_value(out_value), .out_end_of_run(out_end_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Items waiting to be driven, and results still owed by the block.
  cmd_item_t     cmd_q[$];
  entry_result_t owed_q[$];
  int            errors = 0;
  int unsigned   cycles = 0;

  // Predicted contents of both tables and the state of the running tile update.
  int        q_tab[int];
  int        h_tab[int];
  bit [9:0]  run_rows[4];
  int        run_count = 0;
  int        run_best = 32'sh8000_0000;
  bit [16:0] alpha = LR_RESET;
  bit [16:0] gamma = DISC_RESET;

  // The stimulus side keeps its own record of which entries were written, so that
  // no item ever makes the block read an entry that holds no defined value.
  bit        q_known[int];
  bit        h_known[int];
  bit [9:0]  gen_rows[$];
  bit [9:0]  row_pool[8];

  // Driver state.
  cmd_item_t cur;
  bit        took = 0;
  bit        start_r = 0;
  int        gap = 0;
  bit        no_gaps = 0;

  function automatic int col_of(bit [7:0] a);
    if (a == 0) return 0;
    if (a > NUM_COLS) return NUM_COLS - 1;
    return a - 1;
  endfunction

  // Arithmetic shift gives floor division, so adding half first rounds to nearest
  // with ties going toward plus infinity.
  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  // Applies one accepted item to the predicted tables and queues the results it owes.
  function automatic void apply_item(cmd_item_t c);
    int col;
    int addr;
    int srow;
    int e;
    longint g;
    longint d;
    longint nv;
    entry_result_t res;
    col = col_of(c.act);
    addr = c.row * NUM_COLS + col;
    case (c.func)
      FN_WRITE: begin
        if (c.tsel) h_tab[addr] = c.val;
        else q_tab[addr] = c.val;
      end
      FN_READ: begin
        res.kind = 1'b0;
        res.row = c.row;
        res.value = c.tsel ? h_tab[addr] : q_tab[addr];
        res.eor = 1'b0;
        owed_q.insert(owed_q.size(), res);
      end
      FN_STEP: begin
        // The search row is reduced modulo the 1024-row table; it never passes row 1023.
        srow = (c.vis + c.tile * 256) % 1024;
        if (h_tab[srow * NUM_COLS + col] > run_best) run_best = h_tab[srow * NUM_COLS + col];
        if (q_tab[srow * NUM_COLS + col] > run_best) run_best = q_tab[srow * NUM_COLS + col];
        // Rows beyond the fourth still feed the maximum but are never updated.
        if (run_count < 4) begin
          run_rows[run_count] = c.row;
          run_count++;
        end
        if (c.last) begin
          g = round_q16(longint'(gamma) * run_best);
          for (int i = 0; i < run_count; i++) begin
            addr = run_rows[i] * NUM_COLS + col;
            e = c.tsel ? h_tab[addr] : q_tab[addr];
            d = longint'(c.rew) + g - e;
            nv = e + round_q16(longint'(alpha) * d);
            if (nv > 64'sd2147483647) nv = 64'sd2147483647;
            if (nv < -64'sd2147483648) nv = -64'sd2147483648;
            if (c.tsel) h_tab[addr] = int'(nv);
            else q_tab[addr] = int'(nv);
            res.kind = 1'b1;
            res.row = run_rows[i];
            res.value = int'(nv);
            res.eor = (i + 1 == run_count);
            owed_q.insert(owed_q.size(), res);
          end
          run_count = 0;
          run_best = 32'sh8000_0000;
        end
      end
      default: ;  // The unused function code does nothing at all.
    endcase
  endfunction

  // Values lean toward the saturation limits and zero now and then.
  function automatic bit signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 262143) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [9:0] pick_row();
    if ($urandom_range(0, 2) == 0) return 10'($urandom_range(0, 1023));
    return row_pool[$urandom_range(0, 7)];
  endfunction

  function automatic void push_write(bit tsel, bit [9:0] row, bit [7:0] act,
                                     bit signed [31:0] val);
    cmd_item_t c;
    c.func = FN_WRITE;
    c.tsel = tsel;
    c.row = row;
    c.act = act;
    c.val = val;
    c.tile = 2'($urandom);
    c.vis = 8'($urandom);
    c.rew = $urandom;
    c.last = 1'($urandom);
    if (tsel) h_known[row * NUM_COLS + col_of(act)] = 1'b1;
    else q_known[row * NUM_COLS + col_of(act)] = 1'b1;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  // Writes an entry first if it has never been written.
  function automatic void fill_entry(bit tsel, bit [9:0] row, int col);
    if (tsel ? !h_known.exists(row * NUM_COLS + col) : !q_known.exists(row * NUM_COLS + col))
      push_write(tsel, row, 8'(col + 1), pick_value());
  endfunction

  function automatic void push_read(bit tsel, bit [9:0] row, bit [7:0] act);
    cmd_item_t c;
    fill_entry(tsel, row, col_of(act));
    c.func = FN_READ;
    c.tsel = tsel;
    c.row = row;
    c.act = act;
    c.val = $urandom;
    c.tile = 2'($urandom);
    c.vis = 8'($urandom);
    c.rew = $urandom;
    c.last = 1'($urandom);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic void push_step(bit tsel, bit [9:0] row, bit [7:0] act, bit [1:0] tile,
                                    bit [7:0] vis, bit signed [31:0] rew, bit last);
    cmd_item_t c;
    int col;
    int srow;
    col = col_of(act);
    srow = (vis + tile * 256) % 1024;
    fill_entry(1'b0, 10'(srow), col);
    fill_entry(1'b1, 10'(srow), col);
    if (gen_rows.size() < 4) gen_rows.insert(gen_rows.size(), row);
    if (last) begin
      foreach (gen_rows[i]) fill_entry(tsel, gen_rows[i], col);
      gen_rows.delete();
    end
    c.func = FN_STEP;
    c.tsel = tsel;
    c.row = row;
    c.act = act;
    c.val = $urandom;
    c.tile = tile;
    c.vis = vis;
    c.rew = rew;
    c.last = last;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic void push_unused();
    cmd_item_t c;
    c.func = FN_NONE;
    c.tsel = 1'($urandom);
    c.row = 10'($urandom);
    c.act = 8'($urandom);
    c.val = $urandom;
    c.tile = 2'($urandom);
    c.vis = 8'($urandom);
    c.rew = $urandom;
    c.last = 1'($urandom);
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  // A whole tile run of one to six steps on one table; most runs keep one action.
  function automatic void push_run();
    int len;
    bit tsel;
    bit [7:0] act;
    len = $urandom_range(1, 6);
    tsel = 1'($urandom);
    act = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) act = 8'($urandom);
      push_step(tsel, pick_row(), act, 2'($urandom), 8'($urandom), pick_value(),
                i == len - 1);
    end
  endfunction

  function automatic void push_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        6: push_write(1'($urandom), pick_row(), 8'($urandom), pick_value());
        7, 8: push_read(1'($urandom), pick_row(), 8'($urandom));
        9: push_unused();
        default: push_run();
      endcase
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Inputs change on the falling edge. A start that stays high for the next item
  // is assigned once, so back-to-back items never drop it for a step.
  always @(negedge clk) begin
    bit nxt;
    nxt = start_r;
    if (took) begin
      took = 1'b0;
      nxt = 1'b0;
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
      gap = no_gaps ? 0 : int'($urandom_range(0, 8));
    end
    if (!nxt && rst_n) begin
      if (gap > 0) begin
        gap--;
      end else if (cmd_q.size() > 0) begin
        cur = cmd_q.pop_front();
        in_func <= cur.func;
        in_table_sel <= cur.tsel;
        in_abs_row <= cur.row;
        in_action <= cur.act;
        in_entry_value <= cur.val;
        in_tile <= cur.tile;
        in_visit_row <= cur.vis;
        in_reward <= cur.rew;
        in_last <= cur.last;
        nxt = 1'b1;
      end
    end
    start <= nxt;
    start_r = nxt;
  end

  // The monitor samples on the rising edge: it predicts each accepted item and
  // checks each strobed result against the oldest owed one.
  always @(posedge clk) begin
    entry_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results owed", $time, owed_q.size());
      $display("FAIL");
      $finish;
    end
    if (rst_n && start && !busy) begin
      apply_item(cur);
      took = 1'b1;
    end
    if (rst_n && out_valid) begin
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d row %0d value %0d eor %0d", $time,
                 out_kind, out_row, out_value, out_end_of_run);
      end else begin
        want = owed_q.pop_front();
        if (out_kind !== want.kind || out_row !== want.row ||
            out_value !== want.value || out_end_of_run !== want.eor) begin
          errors++;
          $display("%0t: mismatch expected kind %0d row %0d value %0d eor %0d,",
                   $time, want.kind, want.row, want.value, want.eor);
          $display("  got kind %0d row %0d value %0d eor %0d",
                   out_kind, out_row, out_value, out_end_of_run);
        end
      end
    end
  end

  // Register writes only happen with the block idle, then the value is read back.
  task automatic write_reg(bit idx, bit [16:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= {15'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx) gamma = val;
    else alpha = val;
    @(negedge clk);
    psel <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {15'd0, val}) begin
      errors++;
      $display("%0t: register %0d read expected %0d, got %0d", $time, idx, val, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the sender until the queue is drained, every result is in, and the block
  // has had time to finish an item that owes nothing.
  task automatic settle();
    while (cmd_q.size() > 0 || start_r || owed_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    bit [16:0] lr_set[6];
    bit [16:0] dc_set[6];
    start = 1'b0;
    in_func = FN_WRITE;
    in_table_sel = 1'b0;
    in_abs_row = '0;
    in_action = '0;
    in_entry_value = '0;
    in_tile = '0;
    in_visit_row = '0;
    in_reward = '0;
    in_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    foreach (row_pool[i]) row_pool[i] = 10'($urandom_range(0, 1023));
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items: value and field extremes, both tables, every function code,
    // out-of-range actions, the last search row and a run with more tiles than slots.
    push_write(1'b0, 10'd1023, 8'd128, 32'sh7fff_ffff);
    push_write(1'b1, 10'd0, 8'd1, 32'sh8000_0000);
    push_read(1'b0, 10'd1023, 8'd128);
    push_read(1'b1, 10'd0, 8'd0);
    push_write(1'b1, 10'd512, 8'd255, 32'sh0001_0000);
    push_read(1'b1, 10'd512, 8'd128);
    push_unused();
    push_step(1'b0, 10'd1023, 8'd200, 2'd3, 8'd255, 32'sh7fff_ffff, 1'b1);
    for (int i = 0; i < 5; i++)
      push_step(1'b1, row_pool[i % 3], 8'd7, 2'(i), 8'(255 - i), 32'sh8000_0000, i == 4);
    push_step(1'b0, 10'd0, 8'd0, 2'd0, 8'd0, 32'sh0000_0000, 1'b1);
    settle();

    // Register settings, extremes included: above one, zero, and full scale.
    lr_set = '{17'd65536, 17'd0, 17'h1ffff, 17'd32768, 17'd6554, 17'($urandom)};
    dc_set = '{17'd65536, 17'd0, 17'h1ffff, 17'd0, 17'd65535, 17'($urandom)};
    push_random(4);
    settle();
    foreach (lr_set[p]) begin
      write_reg(1'b0, lr_set[p]);
      write_reg(1'b1, dc_set[p]);
      push_random(4);
      settle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
